// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the checker files
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPT_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tpt check failed");

// next-cycle implication
`define TPT_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tpt check failed");

`endif

// ----- rtl/core/tpt_pkg.sv -----
package tpt_pkg;

    localparam int TPT_TLB_ENTRIES = 16;
    localparam int TPT_PAGE_COUNT  = 256;
    localparam int TPT_MAX_FRAMES  = 256;

    // widest tlb index the struct carries
    localparam int TLB_IDX_W = 6;

    localparam int IN_W  = 16;
    localparam int OUT_W = 48;
    localparam int CFG_W = 9;

    localparam logic [1:0] MODE_DEMAND = 2'd0;
    localparam logic [1:0] MODE_FIFO   = 2'd1;
    localparam logic [1:0] MODE_LRU    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    localparam logic [8:0] FRAMES_RESET = 9'd256;

    typedef struct packed {
        logic [TLB_IDX_W-1:0] idx;
        logic                 inv;
        logic                 fill;
        logic [7:0]           fill_page;
        logic [7:0]           fill_frame;
    } tlb_cmd_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] page;
        logic [7:0] frame;
    } tlb_rsp_t;

endpackage

// ----- rtl/core/tpt_tlb.sv -----
module tpt_tlb #(
    parameter int TLB_ENTRIES = tpt_pkg::TPT_TLB_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tpt_pkg::tlb_cmd_t cmd,
    output tpt_pkg::tlb_rsp_t rsp
);
    import tpt_pkg::*;

    localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [7:0]             page_reg  [TLB_ENTRIES];
    logic [7:0]             frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [TLB_ENTRIES-1:0] valid_next;
    logic [TW-1:0]          slot_reg;
    logic [TW-1:0]          slot_next;
    logic [TW-1:0]          idx;

    assign idx = cmd.idx[TW-1:0];

    // one entry looked at per cycle, chosen by the scan index
    assign rsp.valid = valid_reg[idx];
    assign rsp.page  = page_reg[idx];
    assign rsp.frame = frame_reg[idx];

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (cmd.inv)
        begin
            valid_next[idx] = 1'b0;
        end
        if (cmd.fill)
        begin
            valid_next[slot_reg] = 1'b1;
            slot_next = (slot_reg == TW'(TLB_ENTRIES - 1)) ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            page_reg[slot_reg]  <= cmd.fill_page;
            frame_reg[slot_reg] <= cmd.fill_frame;
        end
    end

endmodule

// ----- rtl/core/tlb_page_table_translator.sv -----
// tlb and demand-paging translator. a 16-bit virtual address request on s_*
// is split into page (upper byte) and offset; the page is looked up in a
// fifo-filled tlb, then in the page table, and on a miss in both a frame is
// handed out in ascending order or, once all are used, taken back by fifo or
// lru order (replace_mode). the old owner of a taken frame is dropped from the
// page table and the tlb. one result per request leaves on m_*. one request is
// worked at a time: the tlb is scanned one entry per cycle, the page table and
// order list are memories with one read and one write port, the frame owner
// table is single-port, and every order-list update walks the list one entry
// per step. registers are written on cfg_we with cfg_index 0 for replace_mode
// and 1 for frames_in_use; the user must write them only while the block is
// idle, which the block itself does not enforce.
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = tpt_pkg::TPT_TLB_ENTRIES,
    parameter int PAGE_COUNT  = tpt_pkg::TPT_PAGE_COUNT,
    parameter int MAX_FRAMES  = tpt_pkg::TPT_MAX_FRAMES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // virtual_address[15:0]
    input  logic [tpt_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // physical_address[15:0], frame_id[23:16], tlb_hit[24], fault_flag[25],
    // load_page[33:26], evicted_valid[34], evicted_page[42:35], no_frame[43]
    output logic [tpt_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [tpt_pkg::CFG_W-1:0]  cfg_data
);
    import tpt_pkg::*;

    localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int PW = $clog2(PAGE_COUNT);
    localparam int FW = $clog2(MAX_FRAMES);
    localparam int CW = FW + 1;

    // page number folding into the table range
    typedef logic [7:0] mtab_t [256];

    function automatic mtab_t build_mod_tab();
        mtab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'(i % PAGE_COUNT);
        end
        return t;
    endfunction

    localparam mtab_t MOD_TAB = build_mod_tab();

    typedef enum logic [16:0] {
        ST_IDLE     = 17'h00001,
        ST_TLB_SCAN = 17'h00002,
        ST_PT_RD    = 17'h00004,
        ST_PT_CHK   = 17'h00008,
        ST_ORD0_RD  = 17'h00010,
        ST_ORD0_CHK = 17'h00020,
        ST_OWN_RD   = 17'h00040,
        ST_OWN_CHK  = 17'h00080,
        ST_OPT_CHK  = 17'h00100,
        ST_INV_SCAN = 17'h00200,
        ST_COMMIT   = 17'h00400,
        ST_FILL     = 17'h00800,
        ST_TB_RD    = 17'h01000,
        ST_TB_CMP   = 17'h02000,
        ST_SH_RD    = 17'h04000,
        ST_SH_WR    = 17'h08000,
        ST_OUT      = 17'h10000
    } state_t;

    // where the order-list update goes back to
    typedef enum logic [1:0] {
        RET_COMMIT = 2'd0,
        RET_OWNER  = 2'd1,
        RET_OUT    = 2'd2
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    logic [1:0]  mode_cfg_reg, mode_cfg_next;
    logic [8:0]  frames_cfg_reg, frames_cfg_next;

    logic [7:0]  page_reg, page_next;
    logic [7:0]  offset_reg, offset_next;
    logic [1:0]  mode_reg, mode_next;
    logic [8:0]  limit_reg, limit_next;
    logic [TW-1:0] idx_reg, idx_next;
    logic [7:0]  fr_reg, fr_next;
    logic [7:0]  owner_reg, owner_next;
    logic        hit_reg, hit_next;
    logic        fault_reg, fault_next;
    logic        evv_reg, evv_next;
    logic [7:0]  evp_reg, evp_next;
    logic        none_reg, none_next;
    logic [CW-1:0] ffc_reg, ffc_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] ptr_p1;
    logic [PAGE_COUNT-1:0] pt_valid_reg, pt_valid_next;

    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    // page table, frame owner table and order list
    logic [7:0] pt_mem  [PAGE_COUNT];
    logic [7:0] own_mem [MAX_FRAMES];
    logic [7:0] ord_mem [MAX_FRAMES];
    logic [7:0] pt_q, own_q, ord_q;

    logic [PW-1:0] pt_raddr;
    logic          pt_we;
    logic          own_we;
    logic [FW-1:0] ord_raddr;
    logic          ord_we;
    logic [FW-1:0] ord_waddr;
    logic [7:0]    ord_wdata;

    tlb_cmd_t tlb_cmd;
    tlb_rsp_t tlb_rsp;

    logic [7:0] in_page;
    logic [8:0] in_limit;
    logic [7:0] owner_f;
    logic       tlb_match;
    logic       idx_last;

    tpt_tlb #(
        .TLB_ENTRIES(TLB_ENTRIES)
    ) u_tlb (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (tlb_cmd),
        .rsp  (tlb_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign in_page  = MOD_TAB[s_tdata[15:8]];
    // zero frames acts as one, above the pool acts as the pool size
    assign in_limit = (frames_cfg_reg == 9'd0) ? 9'd1 :
                      (frames_cfg_reg > 9'(MAX_FRAMES)) ? 9'(MAX_FRAMES) : frames_cfg_reg;
    assign owner_f  = MOD_TAB[own_q];
    assign ptr_p1   = ptr_reg + 1'b1;
    assign tlb_match = tlb_rsp.valid && (tlb_rsp.page == page_reg);
    assign idx_last  = (idx_reg == TW'(TLB_ENTRIES - 1));

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        mode_cfg_next   = mode_cfg_reg;
        frames_cfg_next = frames_cfg_reg;
        page_next       = page_reg;
        offset_next     = offset_reg;
        mode_next       = mode_reg;
        limit_next      = limit_reg;
        idx_next        = idx_reg;
        fr_next         = fr_reg;
        owner_next      = owner_reg;
        hit_next        = hit_reg;
        fault_next      = fault_reg;
        evv_next        = evv_reg;
        evp_next        = evp_reg;
        none_next       = none_reg;
        ffc_next        = ffc_reg;
        len_next        = len_reg;
        ptr_next        = ptr_reg;
        pt_valid_next   = pt_valid_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        pt_raddr  = page_reg[PW-1:0];
        pt_we     = 1'b0;
        own_we    = 1'b0;
        ord_raddr = ptr_reg[FW-1:0];
        ord_we    = 1'b0;
        ord_waddr = ptr_reg[FW-1:0];
        ord_wdata = fr_reg;

        tlb_cmd            = '0;
        tlb_cmd.idx        = TLB_IDX_W'(idx_reg);
        tlb_cmd.fill_page  = page_reg;
        tlb_cmd.fill_frame = fr_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   mode_cfg_next   = cfg_data[1:0];
                REG_FRAMES: frames_cfg_next = cfg_data;
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    page_next   = in_page;
                    offset_next = s_tdata[7:0];
                    mode_next   = (mode_cfg_reg == MODE_UNUSED) ? MODE_DEMAND : mode_cfg_reg;
                    limit_next  = in_limit;
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    fault_next  = 1'b0;
                    evv_next    = 1'b0;
                    evp_next    = '0;
                    none_next   = 1'b0;
                    state_next  = ST_TLB_SCAN;
                end
            end
            ST_TLB_SCAN:
            begin
                if (tlb_match)
                begin
                    hit_next = 1'b1;
                    fr_next  = tlb_rsp.frame;
                    if (mode_reg == MODE_LRU)
                    begin
                        ptr_next   = '0;
                        ret_next   = RET_OUT;
                        state_next = ST_TB_RD;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
                else if (idx_last)
                begin
                    state_next = ST_PT_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_PT_RD:
            begin
                state_next = ST_PT_CHK;
            end
            ST_PT_CHK:
            begin
                if (pt_valid_reg[page_reg[PW-1:0]])
                begin
                    fr_next    = pt_q;
                    state_next = ST_FILL;
                end
                else if (9'(ffc_reg) < limit_reg)
                begin
                    // fresh frame, appended to the order list
                    fr_next    = 8'(ffc_reg);
                    ffc_next   = ffc_reg + 1'b1;
                    ptr_next   = '0;
                    ret_next   = RET_COMMIT;
                    state_next = ST_TB_RD;
                end
                else if (mode_reg != MODE_DEMAND && len_reg != '0)
                begin
                    state_next = ST_ORD0_RD;
                end
                else
                begin
                    none_next  = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_ORD0_RD:
            begin
                ord_raddr  = '0;
                state_next = ST_ORD0_CHK;
            end
            ST_ORD0_CHK:
            begin
                // victim is the head of the order list
                fr_next    = ord_q;
                ptr_next   = '0;
                ret_next   = RET_OWNER;
                state_next = ST_TB_RD;
            end
            ST_OWN_RD:
            begin
                state_next = ST_OWN_CHK;
            end
            ST_OWN_CHK:
            begin
                owner_next = owner_f;
                pt_raddr   = owner_f[PW-1:0];
                state_next = ST_OPT_CHK;
            end
            ST_OPT_CHK:
            begin
                // owner only dropped if it still maps to this frame
                if (pt_valid_reg[owner_reg[PW-1:0]] && pt_q == fr_reg)
                begin
                    pt_valid_next[owner_reg[PW-1:0]] = 1'b0;
                    evv_next   = 1'b1;
                    evp_next   = owner_reg;
                    idx_next   = '0;
                    state_next = ST_INV_SCAN;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_INV_SCAN:
            begin
                tlb_cmd.inv = tlb_rsp.valid && (tlb_rsp.page == owner_reg);
                if (idx_last)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_COMMIT:
            begin
                fault_next = 1'b1;
                pt_we      = 1'b1;
                own_we     = 1'b1;
                pt_valid_next[page_reg[PW-1:0]] = 1'b1;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                tlb_cmd.fill = 1'b1;
                if (mode_reg == MODE_LRU)
                begin
                    ptr_next   = '0;
                    ret_next   = RET_OUT;
                    state_next = ST_TB_RD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_TB_RD:
            begin
                // search for the frame, append when absent
                if (ptr_reg >= len_reg)
                begin
                    if (len_reg < CW'(MAX_FRAMES))
                    begin
                        ord_we    = 1'b1;
                        ord_waddr = len_reg[FW-1:0];
                        len_next  = len_reg + 1'b1;
                    end
                    case (ret_reg)
                        RET_COMMIT: state_next = ST_COMMIT;
                        RET_OWNER:  state_next = ST_OWN_RD;
                        default:    state_next = ST_OUT;
                    endcase
                end
                else
                begin
                    state_next = ST_TB_CMP;
                end
            end
            ST_TB_CMP:
            begin
                if (ord_q == fr_reg)
                begin
                    state_next = ST_SH_RD;
                end
                else
                begin
                    ptr_next   = ptr_p1;
                    state_next = ST_TB_RD;
                end
            end
            ST_SH_RD:
            begin
                if (ptr_p1 < len_reg)
                begin
                    ord_raddr  = ptr_p1[FW-1:0];
                    state_next = ST_SH_WR;
                end
                else
                begin
                    ord_we = 1'b1;
                    case (ret_reg)
                        RET_COMMIT: state_next = ST_COMMIT;
                        RET_OWNER:  state_next = ST_OWN_RD;
                        default:    state_next = ST_OUT;
                    endcase
                end
            end
            ST_SH_WR:
            begin
                ord_we     = 1'b1;
                ord_wdata  = ord_q;
                ptr_next   = ptr_p1;
                state_next = ST_SH_RD;
            end
            ST_OUT:
            begin
                // wait for the output register to drain
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    if (none_reg)
                    begin
                        m_data_next     = '0;
                        m_data_next[43] = 1'b1;
                    end
                    else
                    begin
                        m_data_next        = '0;
                        m_data_next[15:0]  = {fr_reg, offset_reg};
                        m_data_next[23:16] = fr_reg;
                        m_data_next[24]    = hit_reg;
                        m_data_next[25]    = fault_reg;
                        m_data_next[33:26] = fault_reg ? page_reg : 8'd0;
                        m_data_next[34]    = evv_reg;
                        m_data_next[42:35] = evp_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= RET_OUT;
            mode_cfg_reg   <= MODE_DEMAND;
            frames_cfg_reg <= FRAMES_RESET;
            ffc_reg        <= '0;
            len_reg        <= '0;
            pt_valid_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            mode_cfg_reg   <= mode_cfg_next;
            frames_cfg_reg <= frames_cfg_next;
            ffc_reg        <= ffc_next;
            len_reg        <= len_next;
            pt_valid_reg   <= pt_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        page_reg   <= page_next;
        offset_reg <= offset_next;
        mode_reg   <= mode_next;
        limit_reg  <= limit_next;
        idx_reg    <= idx_next;
        fr_reg     <= fr_next;
        owner_reg  <= owner_next;
        hit_reg    <= hit_next;
        fault_reg  <= fault_next;
        evv_reg    <= evv_next;
        evp_reg    <= evp_next;
        none_reg   <= none_next;
        ptr_reg    <= ptr_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[page_reg[PW-1:0]] <= fr_reg;
        end
        pt_q <= pt_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[fr_reg[FW-1:0]] <= page_reg;
        end
        own_q <= own_mem[fr_reg[FW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_q <= ord_mem[ord_raddr];
    end

endmodule

// ----- rtl/core/tpt_checker.sv -----
`include "assert_macros.svh"

module tpt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [tpt_pkg::OUT_W-1:0]  m_tdata
);
    import tpt_pkg::*;

    // a held result keeps its payload
    `TPT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one request at a time
    `TPT_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)

    // no frame result carries nothing else
    `TPT_ASSERT_IMP(a_no_frame_clean, m_tvalid && m_tdata[43], m_tdata[42:0] == 43'd0)

    // a tlb hit never faults or evicts
    `TPT_ASSERT_IMP(a_hit_no_fault, m_tvalid && m_tdata[24], !m_tdata[25] && !m_tdata[34])

    // address upper byte is the frame
    `TPT_ASSERT_IMP(a_frame_match, m_tvalid, m_tdata[15:8] == m_tdata[23:16])

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (.*);
